[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge, quiet while reset is asserted.
`define CHK_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Checked at every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

[src/ifau_pkg.sv]
// ----------------------------------------------------------------------------
// ifau_pkg
// Shared constants, register indexes and saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ifau_pkg;

    localparam int unsigned VEC_W    = 48;
    localparam int unsigned ORIGIN_W = 60;
    localparam int unsigned IN_W     = 304;
    localparam int unsigned OUT_W    = 208;

    localparam logic [1:0] REG_ROW0   = 2'd0;
    localparam logic [1:0] REG_ROW1   = 2'd1;
    localparam logic [1:0] REG_ROW2   = 2'd2;
    localparam logic [1:0] REG_CENTER = 2'd3;

    localparam logic [47:0] ROW0_RESET = 48'h0000_0000_4000;
    localparam logic [47:0] ROW1_RESET = 48'h0000_4000_0000;
    localparam logic [47:0] ROW2_RESET = 48'h4000_0000_0000;

    function automatic logic signed [15:0] sat_q14(input logic signed [20:0] v);
        logic signed [15:0] r;
        if (v > 21'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -21'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [43:0] v);
        logic signed [19:0] r;
        if (v > 44'sd524287)
        begin
            r = 20'sh7ffff;
        end
        else if (v < -44'sd524288)
        begin
            r = 20'sh80000;
        end
        else
        begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/ifau_orient.sv]
// ----------------------------------------------------------------------------
// ifau_orient
// Orientation product (T*R or R*T) and plain-mode origin T*o, five stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifau_orient (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic         center_mode,
    input  wire logic [143:0] t_rows,
    input  wire logic [143:0] r_cols,
    input  wire logic [59:0]  origin,
    output logic      [143:0] orient,
    output logic      [59:0]  plain_origin
);

    logic signed [15:0] rm [3][3];
    logic signed [15:0] tm [3][3];
    logic signed [19:0] om [3];

    logic signed [31:0] prod_next [3][3][3];
    logic signed [31:0] prod_reg  [3][3][3];
    logic signed [35:0] oprod_next [3][3];
    logic signed [35:0] oprod_reg  [3][3];

    logic [203:0] res_next;
    logic [203:0] dly_reg [4];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            om[r] = $signed(origin[20*r +: 20]);
            for (int c = 0; c < 3; c++)
            begin
                rm[r][c] = $signed(r_cols[48*c + 16*r +: 16]);
                tm[r][c] = $signed(t_rows[48*r + 16*c +: 16]);
            end
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_next[r][c][k] = center_mode ? rm[r][k] * tm[k][c]
                                                     : tm[r][k] * rm[k][c];
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                oprod_next[r][k] = tm[r][k] * om[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            oprod_reg <= oprod_next;
        end
    end

    always_comb
    begin
        logic signed [34:0] s;
        logic signed [38:0] so;
        res_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s = 35'(prod_reg[r][c][0]) + 35'(prod_reg[r][c][1])
                  + 35'(prod_reg[r][c][2]) + 35'sd8192;
                res_next[48*c + 16*r +: 16] = ifau_pkg::sat_q14($signed(s[34:14]));
            end
            so = 39'(oprod_reg[r][0]) + 39'(oprod_reg[r][1])
               + 39'(oprod_reg[r][2]) + 39'sd8192;
            res_next[144 + 20*r +: 20] = ifau_pkg::sat20(44'($signed(so[38:14])));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= res_next;
            dly_reg[1] <= dly_reg[0];
            dly_reg[2] <= dly_reg[1];
            dly_reg[3] <= dly_reg[2];
        end
    end

    assign orient       = dly_reg[3][143:0];
    assign plain_origin = dly_reg[3][203:144];

endmodule

`default_nettype wire

[src/ifau_center.sv]
// ----------------------------------------------------------------------------
// ifau_center
// Center-mode origin o + R*(I-T)*h with singularity test, five stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifau_center (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [143:0] t_rows,
    input  wire logic [143:0] r_cols,
    input  wire logic [59:0]  origin,
    input  wire logic [47:0]  voxel_scale,
    input  wire logic [47:0]  image_size,
    output logic      [59:0]  center_origin,
    output logic              singular
);

    logic signed [15:0] tm [3][3];
    logic signed [33:0] h_next [3];
    logic signed [33:0] h_reg  [3];
    logic signed [16:0] imt_next [3][3];
    logic signed [16:0] imt_reg  [3][3];
    logic signed [31:0] cofp_next [6];
    logic signed [31:0] cofp_reg  [6];
    logic [143:0] r1_reg, r2_reg, r3_reg;
    logic [59:0]  o1_reg, o2_reg, o3_reg, o4_reg;

    logic signed [50:0] hp_next [3][3];
    logic signed [50:0] hp_reg  [3][3];
    logic signed [48:0] detp_next [3];
    logic signed [48:0] detp_reg  [3];

    logic signed [41:0] d_next [3];
    logic signed [41:0] d_reg  [3];
    logic sing_next, sing3_reg, sing4_reg, sing5_reg;

    logic signed [57:0] rd_next [3][3];
    logic signed [57:0] rd_reg  [3][3];

    logic [59:0] out_next, out_reg;

    function automatic logic signed [15:0] rel(input logic [143:0] v, input int r, input int c);
        return $signed(v[48*c + 16*r +: 16]);
    endfunction

    always_comb
    begin
        logic signed [16:0] sc;
        logic signed [16:0] szm;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                tm[r][c] = $signed(t_rows[48*r + 16*c +: 16]);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            sc  = $signed({1'b0, voxel_scale[16*k +: 16]});
            szm = $signed({1'b0, image_size[16*k +: 16]}) - 17'sd1;
            h_next[k] = sc * szm;
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                imt_next[r][k] = ((r == k) ? 17'sd16384 : 17'sd0) - 17'(tm[r][k]);
            end
        end
        cofp_next[0] = rel(r_cols, 1, 1) * rel(r_cols, 2, 2);
        cofp_next[1] = rel(r_cols, 1, 2) * rel(r_cols, 2, 1);
        cofp_next[2] = rel(r_cols, 1, 0) * rel(r_cols, 2, 2);
        cofp_next[3] = rel(r_cols, 1, 2) * rel(r_cols, 2, 0);
        cofp_next[4] = rel(r_cols, 1, 0) * rel(r_cols, 2, 1);
        cofp_next[5] = rel(r_cols, 1, 1) * rel(r_cols, 2, 0);
    end

    always_comb
    begin
        logic signed [32:0] cd;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                hp_next[r][k] = imt_reg[r][k] * h_reg[k];
            end
        end
        for (int j = 0; j < 3; j++)
        begin
            cd = 33'(cofp_reg[2*j]) - 33'(cofp_reg[2*j+1]);
            detp_next[j] = rel(r1_reg, 0, j) * cd;
        end
    end

    always_comb
    begin
        logic signed [53:0] s;
        logic signed [50:0] det;
        for (int r = 0; r < 3; r++)
        begin
            s = 54'(hp_reg[r][0]) + 54'(hp_reg[r][1]) + 54'(hp_reg[r][2]) + 54'sd1024;
            d_next[r] = s[52:11];
        end
        det = 51'(detp_reg[0]) - 51'(detp_reg[1]) + 51'(detp_reg[2]);
        sing_next = (det == 51'sd0);
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rd_next[r][k] = rel(r3_reg, r, k) * d_reg[k];
            end
        end
    end

    always_comb
    begin
        logic signed [60:0] s;
        logic signed [43:0] v;
        out_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            s = 61'(rd_reg[r][0]) + 61'(rd_reg[r][1]) + 61'(rd_reg[r][2]) + 61'sd131072;
            v = 44'($signed(s[60:18])) + 44'($signed(o4_reg[20*r +: 20]));
            out_next[20*r +: 20] = ifau_pkg::sat20(v);
        end
        if (sing4_reg)
        begin
            out_next = o4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg     <= h_next;
            imt_reg   <= imt_next;
            cofp_reg  <= cofp_next;
            r1_reg    <= r_cols;
            o1_reg    <= origin;
            hp_reg    <= hp_next;
            detp_reg  <= detp_next;
            r2_reg    <= r1_reg;
            o2_reg    <= o1_reg;
            d_reg     <= d_next;
            sing3_reg <= sing_next;
            r3_reg    <= r2_reg;
            o3_reg    <= o2_reg;
            rd_reg    <= rd_next;
            sing4_reg <= sing3_reg;
            o4_reg    <= o3_reg;
            out_reg   <= out_next;
            sing5_reg <= sing4_reg;
        end
    end

    assign center_origin = out_reg;
    assign singular      = sing5_reg;

endmodule

`default_nettype wire

[src/image_frame_affine_update_top.sv]
// ----------------------------------------------------------------------------
// image_frame_affine_update_top
// Applies a configured 3x3 transform to an image orientation and origin.
// ----------------------------------------------------------------------------
// The input stream carries one frame description per beat and the output
// stream returns one updated description per beat. The user must write the
// transform rows and the center mode flag through the cfg port only while the
// block is idle; the block itself does not enforce this. An accepted beat
// passes one input register and five arithmetic stages, a depth set by the
// center-mode chain of products (h, then (I-T)*h and R*d, each with its sum).
// Throughput is one beat per cycle while the receiver does not stall; every
// stage holds one beat. When the receiver holds m_axis_tready low with a beat
// waiting, the whole pipeline freezes and s_axis_tready drops in the same
// cycle, so nothing is lost or repeated. Reset clears every valid bit and
// restores the identity transform and plain mode; payload registers keep
// whatever they held. Status on m_axis_tuser is high only in center mode with
// a singular orientation, in which case the origin passes through unchanged.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module image_frame_affine_update_top (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [47:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // row_vec, column_vec, slice_vec, index_origin, voxel_scale, image_size, zero pad
    input  wire logic [303:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // new_row_vec, new_column_vec, new_slice_vec, new_origin, zero pad
    output logic      [207:0] m_axis_tdata,
    // status
    output logic              m_axis_tuser
);

    localparam int unsigned DEPTH = 6;

    logic [47:0] row0_reg, row1_reg, row2_reg;
    logic        center_reg;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic [299:0] in_reg;
    logic         en;

    logic [143:0] t_rows;
    logic [143:0] orient;
    logic [59:0]  plain_origin;
    logic [59:0]  center_origin;
    logic         singular;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg   <= ifau_pkg::ROW0_RESET;
            row1_reg   <= ifau_pkg::ROW1_RESET;
            row2_reg   <= ifau_pkg::ROW2_RESET;
            center_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ifau_pkg::REG_ROW0:   row0_reg   <= cfg_data;
                ifau_pkg::REG_ROW1:   row1_reg   <= cfg_data;
                ifau_pkg::REG_ROW2:   row2_reg   <= cfg_data;
                ifau_pkg::REG_CENTER: center_reg <= cfg_data[0];
                default:              center_reg <= center_reg;
            endcase
        end
    end

    assign en            = !(valid_reg[DEPTH-1] && !m_axis_tready);
    assign s_axis_tready = en;
    assign valid_next    = {valid_reg[DEPTH-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg <= s_axis_tdata[299:0];
        end
    end

    assign t_rows = {row2_reg, row1_reg, row0_reg};

    ifau_orient u_orient (
        .clk          (clk),
        .en           (en),
        .center_mode  (center_reg),
        .t_rows       (t_rows),
        .r_cols       (in_reg[143:0]),
        .origin       (in_reg[203:144]),
        .orient       (orient),
        .plain_origin (plain_origin)
    );

    ifau_center u_center (
        .clk           (clk),
        .en            (en),
        .t_rows        (t_rows),
        .r_cols        (in_reg[143:0]),
        .origin        (in_reg[203:144]),
        .voxel_scale   (in_reg[251:204]),
        .image_size    (in_reg[299:252]),
        .center_origin (center_origin),
        .singular      (singular)
    );

    assign m_axis_tvalid = valid_reg[DEPTH-1];
    assign m_axis_tdata  = {4'b0000, (center_reg ? center_origin : plain_origin), orient};
    assign m_axis_tuser  = center_reg & singular;

endmodule

`default_nettype wire

[src/ifau_checker.sv]
// ----------------------------------------------------------------------------
// ifau_checker
// Port-level checks of the stream handshake and pipeline flow control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ifau_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [207:0] m_axis_tdata,
    input wire logic         m_axis_tuser
);

    logic         stalled;
    logic [208:0] out_beat;

    assign stalled  = m_axis_tvalid && !m_axis_tready;
    assign out_beat = {m_axis_tuser, m_axis_tdata};

    `CHK_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !m_axis_tvalid)
    `CHK_ASSERT(a_ready_follows, clk, rst_n, m_axis_tready |-> s_axis_tready)
    `CHK_ASSERT(a_empty_ready, clk, rst_n, !m_axis_tvalid |-> s_axis_tready)
    `CHK_ASSERT(a_stall_hold, clk, rst_n, stalled |=> (m_axis_tvalid && $stable(out_beat)))

endmodule

bind image_frame_affine_update_top ifau_checker u_ifau_checker (.*);

`default_nettype wire

[test/image_frame_affine_update_top_tb.sv]
// ----------------------------------------------------------------------------
// image_frame_affine_update_top_tb
// Self-checking bench for the orientation and origin transform block.
// ----------------------------------------------------------------------------
// Directed plain-mode rows cover identity, extremes and an all-zero frame;
// center-mode rows cover singular orientations and zero image size. Random
// frames then run under several transforms; every beat is compared field by
// field to a bit-exact fixed point predictor, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module image_frame_affine_update_top_tb;

    typedef struct packed {
        logic [59:0] origin;
        logic [47:0] slice_v;
        logic [47:0] col_v;
        logic [47:0] row_v;
    } frame_out_t;

    typedef struct {
        logic [47:0] row_v;
        logic [47:0] col_v;
        logic [47:0] slice_v;
        logic [59:0] origin;
        logic [47:0] scale;
        logic [47:0] size;
    } frame_in_t;

    typedef struct {
        frame_in_t  fin;
        logic       has_exp;
        frame_out_t exp_data;
        logic       exp_status;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [47:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [303:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [207:0] m_axis_tdata;
    logic         m_axis_tuser;

    logic [47:0]  xform_row [3];
    logic         center_on;
    frame_out_t   exp_frames [$];
    logic         exp_stats [$];
    int           n_err;
    int           n_beats_out;
    int           n_center;
    int           n_singular;
    logic         in_run;
    dir_row_t     dir_tab [$];

    image_frame_affine_update_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint rnd_shr(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi)
        begin
            return hi;
        end
        if (v < -hi - 1)
        begin
            return -hi - 1;
        end
        return v;
    endfunction

    function automatic void predict_frame(input frame_in_t f, output frame_out_t fo,
                                          output logic st);
        longint rm [3][3];
        longint tm [3][3];
        longint org [3];
        longint half [3];
        longint dv [3];
        longint acc;
        longint det;
        logic [47:0] cols [3];
        logic [15:0] ent;
        logic [19:0] oc;
        logic [59:0] onew;
        logic [47:0] vn [3];
        cols[0] = f.row_v;
        cols[1] = f.col_v;
        cols[2] = f.slice_v;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                ent = cols[c][16*r +: 16];
                rm[r][c] = longint'($signed(ent));
                ent = xform_row[r][16*c +: 16];
                tm[r][c] = longint'($signed(ent));
            end
            oc = f.origin[20*r +: 20];
            org[r] = longint'($signed(oc));
            half[r] = longint'(f.scale[16*r +: 16]) * (longint'(f.size[16*r +: 16]) - 1);
        end
        st = 1'b0;
        onew = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                begin
                    acc += center_on ? rm[r][k] * tm[k][c] : tm[r][k] * rm[k][c];
                end
                vn[c][16*r +: 16] = 16'(clip(rnd_shr(acc, 14), 16));
            end
        end
        if (!center_on)
        begin
            for (int r = 0; r < 3; r++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                begin
                    acc += tm[r][k] * org[k];
                end
                onew[20*r +: 20] = 20'(clip(rnd_shr(acc, 14), 20));
            end
        end
        else
        begin
            det = rm[0][0] * (rm[1][1] * rm[2][2] - rm[1][2] * rm[2][1])
                - rm[0][1] * (rm[1][0] * rm[2][2] - rm[1][2] * rm[2][0])
                + rm[0][2] * (rm[1][0] * rm[2][1] - rm[1][1] * rm[2][0]);
            if (det == 0)
            begin
                onew = f.origin;
                st = 1'b1;
            end
            else
            begin
                for (int r = 0; r < 3; r++)
                begin
                    acc = 0;
                    for (int k = 0; k < 3; k++)
                    begin
                        acc += ((r == k ? 64'sd16384 : 64'sd0) - tm[r][k]) * half[k];
                    end
                    dv[r] = rnd_shr(acc, 11);
                end
                for (int r = 0; r < 3; r++)
                begin
                    acc = 0;
                    for (int k = 0; k < 3; k++)
                    begin
                        acc += rm[r][k] * dv[k];
                    end
                    onew[20*r +: 20] = 20'(clip(org[r] + rnd_shr(acc, 18), 20));
                end
            end
        end
        fo.row_v = vn[0];
        fo.col_v = vn[1];
        fo.slice_v = vn[2];
        fo.origin = onew;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == ifau_pkg::REG_CENTER)
        begin
            center_on = val[0];
        end
        else
        begin
            xform_row[idx] = val;
        end
        @(posedge clk);
    endtask

    task automatic drain_pipe();
        while (exp_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
        begin
            return $urandom_range(5, 30);
        end
        return $urandom_range(0, 2);
    endfunction

    task automatic send_frame(input frame_in_t f, input logic has_exp,
                              input frame_out_t ed, input logic es, input logic gaps);
        frame_out_t fo;
        logic st;
        int g;
        g = gaps ? gap_len() : 0;
        if (g != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'h0, f.size, f.scale, f.origin, f.slice_v, f.col_v, f.row_v};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        predict_frame(f, fo, st);
        if (has_exp && (fo !== ed || st !== es))
        begin
            $display("%0t table row disagrees with predictor: table %h/%b, predictor %h/%b",
                     $time, ed, es, fo, st);
            n_err++;
        end
        if (center_on)
        begin
            n_center++;
        end
        if (st)
        begin
            n_singular++;
        end
        exp_frames.push_back(fo);
        exp_stats.push_back(st);
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rnd_q14();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h4000;
            3: return 16'hc000;
            4: return 16'(int'($urandom_range(0, 2048)) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] rnd_vec();
        return {rnd_q14(), rnd_q14(), rnd_q14()};
    endfunction

    function automatic frame_in_t rnd_frame();
        frame_in_t f;
        logic [2:0] kind;
        kind = 3'($urandom_range(0, 7));
        f.row_v = rnd_vec();
        f.col_v = rnd_vec();
        f.slice_v = rnd_vec();
        if (kind == 0)
        begin
            f.col_v = f.row_v;
        end
        else if (kind == 1)
        begin
            f.slice_v = '0;
        end
        f.origin = 60'({$urandom, $urandom});
        f.scale = 48'({$urandom, $urandom});
        f.size = 48'({$urandom, $urandom});
        if ($urandom_range(0, 3) != 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                f.scale[16*i +: 16] = 16'($urandom_range(0, 1023));
                f.size[16*i +: 16] = 16'($urandom_range(0, 512));
            end
        end
        return f;
    endfunction

    function automatic frame_in_t mk_frame(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                                           logic [59:0] o, logic [47:0] s, logic [47:0] z);
        frame_in_t f;
        f.row_v = a;
        f.col_v = b;
        f.slice_v = c;
        f.origin = o;
        f.scale = s;
        f.size = z;
        return f;
    endfunction

    // Receiver side: random stalls, checks each beat against the oldest prediction.
    always @(posedge clk)
    begin
        frame_out_t got;
        frame_out_t want;
        logic ws;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = frame_out_t'(m_axis_tdata[203:0]);
                n_beats_out++;
                if (exp_frames.size() == 0)
                begin
                    $display("%0t unexpected output beat %h", $time, m_axis_tdata);
                    n_err++;
                end
                else
                begin
                    want = exp_frames.pop_front();
                    ws = exp_stats.pop_front();
                    if (got.row_v !== want.row_v)
                    begin
                        $display("%0t new_row_vec exp %h got %h", $time, want.row_v, got.row_v);
                        n_err++;
                    end
                    if (got.col_v !== want.col_v)
                    begin
                        $display("%0t new_column_vec exp %h got %h", $time, want.col_v,
                                 got.col_v);
                        n_err++;
                    end
                    if (got.slice_v !== want.slice_v)
                    begin
                        $display("%0t new_slice_vec exp %h got %h", $time, want.slice_v,
                                 got.slice_v);
                        n_err++;
                    end
                    if (got.origin !== want.origin)
                    begin
                        $display("%0t new_origin exp %h got %h", $time, want.origin,
                                 got.origin);
                        n_err++;
                    end
                    if (m_axis_tuser !== ws)
                    begin
                        $display("%0t status exp %b got %b", $time, ws, m_axis_tuser);
                        n_err++;
                    end
                    if (m_axis_tdata[207:204] !== 4'h0)
                    begin
                        $display("%0t pad exp 0 got %h", $time, m_axis_tdata[207:204]);
                        n_err++;
                    end
                end
            end
            if (!in_run || $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b1;
            end
            else if ($urandom_range(0, 29) == 0)
            begin
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 2) != 0);
            end
        end
    end

    initial
    begin
        #30ms;
        $display("FAIL image_frame_affine_update_top");
        $finish;
    end

    initial
    begin
        frame_in_t f;
        frame_out_t nd;
        dir_row_t row;
        logic [47:0] unit;
        logic [47:0] sz1;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = ifau_pkg::REG_ROW0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        n_err = 0;
        n_beats_out = 0;
        n_center = 0;
        n_singular = 0;
        in_run = 1'b0;
        xform_row[0] = ifau_pkg::ROW0_RESET;
        xform_row[1] = ifau_pkg::ROW1_RESET;
        xform_row[2] = ifau_pkg::ROW2_RESET;
        center_on = 1'b0;
        nd = '0;
        unit = 48'h0001_0001_0001;
        sz1 = 48'h0001_0001_0001;

        // Directed rows; identity after reset passes frames unchanged.
        row.has_exp = 1'b1;
        row.exp_status = 1'b0;
        row.fin = mk_frame(ifau_pkg::ROW0_RESET, ifau_pkg::ROW1_RESET, ifau_pkg::ROW2_RESET,
                           60'h00100_00200_00300, unit, sz1);
        row.exp_data = '{origin: 60'h00100_00200_00300, slice_v: ifau_pkg::ROW2_RESET,
                         col_v: ifau_pkg::ROW1_RESET, row_v: ifau_pkg::ROW0_RESET};
        dir_tab.push_back(row);
        row.fin = mk_frame(48'h7fff_8000_7fff, 48'h8000_7fff_8000, '1, 60'h7ffff_80000_fffff,
                           '1, '1);
        row.exp_data = '{origin: 60'h7ffff_80000_fffff, slice_v: '1,
                         col_v: 48'h8000_7fff_8000, row_v: 48'h7fff_8000_7fff};
        dir_tab.push_back(row);
        row.fin = mk_frame('0, '0, '0, '0, '0, '0);
        row.exp_data = '0;
        dir_tab.push_back(row);
        row.has_exp = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            row.fin = rnd_frame();
            dir_tab.push_back(row);
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        in_run = 1'b1;

        for (int i = 0; i < dir_tab.size(); i++)
        begin
            send_frame(dir_tab[i].fin, dir_tab[i].has_exp, dir_tab[i].exp_data,
                       dir_tab[i].exp_status, 1'b0);
        end
        idle_input();
        drain_pipe();

        // Center mode with identity: singular input echoes origin and flags status.
        write_reg(ifau_pkg::REG_CENTER, 48'h1);
        row.fin = mk_frame(ifau_pkg::ROW0_RESET, ifau_pkg::ROW0_RESET, ifau_pkg::ROW2_RESET,
                           60'h12345_fedcb_00001, unit, sz1);
        row.exp_data = '{origin: 60'h12345_fedcb_00001, slice_v: ifau_pkg::ROW2_RESET,
                         col_v: ifau_pkg::ROW0_RESET, row_v: ifau_pkg::ROW0_RESET};
        send_frame(row.fin, 1'b1, row.exp_data, 1'b1, 1'b0);
        row.fin = mk_frame('0, '0, '0, 60'h80000_7ffff_00000, '1, '0);
        row.exp_data = '{origin: 60'h80000_7ffff_00000, slice_v: '0, col_v: '0, row_v: '0};
        send_frame(row.fin, 1'b1, row.exp_data, 1'b1, 1'b0);
        // Identity transform in center mode leaves a regular frame untouched.
        row.fin = mk_frame(ifau_pkg::ROW0_RESET, ifau_pkg::ROW1_RESET, ifau_pkg::ROW2_RESET,
                           60'h00100_00200_00300, '1, '0);
        row.exp_data = '{origin: 60'h00100_00200_00300, slice_v: ifau_pkg::ROW2_RESET,
                         col_v: ifau_pkg::ROW1_RESET, row_v: ifau_pkg::ROW0_RESET};
        send_frame(row.fin, 1'b1, row.exp_data, 1'b0, 1'b0);
        idle_input();
        drain_pipe();

        // Random phases over several transforms, extremes included.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(ifau_pkg::REG_ROW0, 48'h0000_4000_0000);
                    write_reg(ifau_pkg::REG_ROW1, 48'h0000_0000_c000);
                    write_reg(ifau_pkg::REG_ROW2, ifau_pkg::ROW2_RESET);
                end
                1:
                begin
                    write_reg(ifau_pkg::REG_ROW0, '1);
                    write_reg(ifau_pkg::REG_ROW1, 48'h7fff_7fff_7fff);
                    write_reg(ifau_pkg::REG_ROW2, 48'h8000_8000_8000);
                end
                2:
                begin
                    write_reg(ifau_pkg::REG_ROW0, '0);
                    write_reg(ifau_pkg::REG_ROW1, '0);
                    write_reg(ifau_pkg::REG_ROW2, '0);
                end
                default:
                begin
                    write_reg(ifau_pkg::REG_ROW0, rnd_vec());
                    write_reg(ifau_pkg::REG_ROW1, rnd_vec());
                    write_reg(ifau_pkg::REG_ROW2, rnd_vec());
                end
            endcase
            write_reg(ifau_pkg::REG_CENTER,
                      48'({$urandom, $urandom}) & 48'hffff_ffff_fffe | 48'(ph & 1));
            for (int i = 0; i < 128; i++)
            begin
                send_frame(rnd_frame(), 1'b0, nd, 1'b0, (ph % 3) != 2);
            end
            idle_input();
            drain_pipe();
        end

        in_run = 1'b0;
        drain_pipe();
        $display("Checked %0d output beats: %0d in center mode, %0d with singular orientation.",
                 n_beats_out, n_center, n_singular);
        if (n_err == 0)
        begin
            $display("PASS image_frame_affine_update_top");
        end
        else
        begin
            $display("FAIL image_frame_affine_update_top");
        end
        $finish;
    end

endmodule

[image_frame_affine_update_top.f]
+incdir+src
src/ifau_pkg.sv
src/ifau_orient.sv
src/ifau_center.sv
src/image_frame_affine_update_top.sv
src/ifau_checker.sv
test/image_frame_affine_update_top_tb.sv
